// ===== rtl/mav_pkg.sv =====
// mav_pkg: sizes, reset pattern, command and status codes and the control
// structs shared by the MSI vector allocator files.
// No dependencies.
package mav_pkg;

   localparam int POOL_SIZE  = 64;
   localparam int SLOT_COUNT = 8;
   localparam int IRQ_BASE   = 64;

   localparam int PoolIdxW  = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam int SlotIdxW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int SlotCodeW = $clog2(SLOT_COUNT + 1);

   localparam logic [63:0] RESERVED_PATTERN = 64'hff00_0000_0000_ffff;
   localparam logic [POOL_SIZE-1:0] PoolResetVal = POOL_SIZE'(RESERVED_PATTERN);

   localparam int CsrAddrW = 3;
   localparam int CsrIdxW  = CsrAddrW - 2;
   localparam int REG_MSI_ENABLE = 0;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_DISABLED = 2'd2,
      STATUS_RANGE    = 2'd3
   } status_type;

   typedef struct packed {
      logic                 alloc_set;
      logic                 pool_clr;
      logic [PoolIdxW-1:0]  pool_clr_idx;
      logic                 slot_clr;
      logic [SlotIdxW-1:0]  slot_clr_idx;
   } bitmap_op_type;

   typedef struct packed {
      logic                 pool_found;
      logic [PoolIdxW-1:0]  pool_idx;
      logic                 slot_found;
      logic [SlotIdxW-1:0]  slot_idx;
   } bitmap_stat_type;

endpackage

// ===== rtl/mav_if.sv =====
// mav_req_if and mav_rsp_if: valid/ready channels of the MSI vector allocator.
// Depend on mav_pkg for the status code type.
interface mav_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] irq_number;

   modport source (output valid, command, irq_number, input ready);
   modport sink (input valid, command, irq_number, output ready);
endinterface

interface mav_rsp_if;
   logic                valid;
   logic                ready;
   mav_pkg::status_type status;
   logic [7:0]          irq_out;
   logic [7:0]          msi_data;
   logic                slot_valid;
   logic [2:0]          slot_index;

   modport source (output valid, status, irq_out, msi_data, slot_valid, slot_index,
                   input ready);
   modport sink (input valid, status, irq_out, msi_data, slot_valid, slot_index,
                 output ready);
endinterface

// ===== rtl/msi_vector_allocator_core.sv =====
// msi_vector_allocator_core: top level of the MSI vector allocator, with the
// command sequencer, the vector-to-slot RAM and the APB register port.
// Depends on mav_pkg, mav_if, mav_ram and mav_bitmap.
//
//   port       role     handshake              payload
//   req_chan   in       valid/ready            command, irq_number
//   rsp_chan   out      valid/ready            status, irq_out, msi_data, slot_*
//   csr_*      config   APB, pready tied high  msi_enable at byte 0
//
// Allocate: result in the cycle after accept, set by the bitmap search.
// Free: out of range at once; else via S_WAIT, reading the vector-to-slot RAM.
// One item in flight; a new item is taken in the cycle its result drains.
// Reset is synchronous; the RAM needs no clearing pass (per-entry valid bits).
// A stalled result holds in the output register.
module msi_vector_allocator_core (
   input  logic                          clock,
   input  logic                          reset,
   mav_req_if.sink                       req_chan,
   mav_rsp_if.source                     rsp_chan,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [mav_pkg::CsrAddrW-1:0]  csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   typedef enum logic {S_IDLE, S_WAIT} state_type;

   state_type                        state_ff, state_in;
   logic                             enable_ff, enable_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   mav_pkg::status_type              status_ff, status_in;
   logic [7:0]                       irq_out_ff, irq_out_in;
   logic [7:0]                       msi_data_ff, msi_data_in;
   logic                             slot_valid_ff, slot_valid_in;
   logic [2:0]                       slot_index_ff, slot_index_in;
   logic [mav_pkg::POOL_SIZE-1:0]    vts_valid_ff, vts_valid_in;
   logic                             rd_valid_ff, rd_valid_in;
   logic [mav_pkg::PoolIdxW-1:0]     free_idx_ff, free_idx_in;

   logic                             accept;
   logic [8:0]                       diff;
   logic                             in_range;
   logic [mav_pkg::PoolIdxW-1:0]     req_idx;
   logic                             ram_we;
   logic [mav_pkg::SlotCodeW-1:0]    ram_wdata;
   logic [mav_pkg::SlotCodeW-1:0]    ram_rdata;
   logic [mav_pkg::SlotCodeW-1:0]    code;
   logic [mav_pkg::SlotCodeW-1:0]    slot_num;
   logic                             csr_wr;
   logic                             csr_hit;
   mav_pkg::bitmap_op_type           bm_op;
   mav_pkg::bitmap_stat_type         bm_stat;

   mav_ram #(
      .WIDTH (mav_pkg::SlotCodeW),
      .DEPTH (mav_pkg::POOL_SIZE)
   ) u_vts_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (bm_stat.pool_idx),
      .wr_data (ram_wdata),
      .rd_addr (req_idx),
      .rd_data (ram_rdata)
   );

   mav_bitmap u_bitmap (
      .clock (clock),
      .reset (reset),
      .op    (bm_op),
      .stat  (bm_stat)
   );

   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[mav_pkg::CsrAddrW-1:2] ==
                       mav_pkg::CsrIdxW'(mav_pkg::REG_MSI_ENABLE);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = csr_hit ? {31'd0, enable_ff} : 32'd0;
   assign enable_in  = (csr_wr && csr_hit) ? csr_pwdata[0] : enable_ff;

   assign req_chan.ready      = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept              = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = status_ff;
   assign rsp_chan.irq_out    = irq_out_ff;
   assign rsp_chan.msi_data   = msi_data_ff;
   assign rsp_chan.slot_valid = slot_valid_ff;
   assign rsp_chan.slot_index = slot_index_ff;

   assign diff     = {1'b0, req_chan.irq_number} - 9'(mav_pkg::IRQ_BASE);
   assign in_range = !diff[8] && (diff < 9'(mav_pkg::POOL_SIZE));
   assign req_idx  = diff[mav_pkg::PoolIdxW-1:0];
   assign code     = rd_valid_ff ? ram_rdata : '0;
   assign slot_num = code - mav_pkg::SlotCodeW'(1);

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      status_in     = status_ff;
      irq_out_in    = irq_out_ff;
      msi_data_in   = msi_data_ff;
      slot_valid_in = slot_valid_ff;
      slot_index_in = slot_index_ff;
      vts_valid_in  = vts_valid_ff;
      rd_valid_in   = rd_valid_ff;
      free_idx_in   = free_idx_ff;
      bm_op         = '0;
      ram_we        = 1'b0;
      ram_wdata     = mav_pkg::SlotCodeW'(bm_stat.slot_idx) + mav_pkg::SlotCodeW'(1);
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rd_valid_in = vts_valid_ff[req_idx];
               free_idx_in = req_idx;
               if (req_chan.command == mav_pkg::CMD_ALLOC) begin
                  rsp_valid_in  = 1'b1;
                  irq_out_in    = '0;
                  msi_data_in   = '0;
                  slot_valid_in = 1'b0;
                  slot_index_in = '0;
                  if (!enable_ff) begin
                     status_in = mav_pkg::STATUS_DISABLED;
                  end else if (!bm_stat.pool_found) begin
                     status_in = mav_pkg::STATUS_FULL;
                  end else begin
                     status_in     = mav_pkg::STATUS_OK;
                     bm_op.alloc_set = 1'b1;
                     irq_out_in    = 8'(mav_pkg::IRQ_BASE + int'(bm_stat.pool_idx));
                     msi_data_in   = 8'(bm_stat.pool_idx);
                     if (bm_stat.slot_found) begin
                        ram_we        = 1'b1;
                        vts_valid_in[bm_stat.pool_idx] = 1'b1;
                        slot_valid_in = 1'b1;
                        slot_index_in = 3'(bm_stat.slot_idx);
                     end
                  end
               end else if (!in_range) begin
                  rsp_valid_in  = 1'b1;
                  status_in     = mav_pkg::STATUS_RANGE;
                  irq_out_in    = '0;
                  msi_data_in   = '0;
                  slot_valid_in = 1'b0;
                  slot_index_in = '0;
               end else begin
                  state_in = S_WAIT;
               end
            end
         end
         S_WAIT: begin
            state_in           = S_IDLE;
            rsp_valid_in       = 1'b1;
            status_in          = mav_pkg::STATUS_OK;
            irq_out_in         = '0;
            msi_data_in        = '0;
            slot_valid_in      = 1'b0;
            slot_index_in      = '0;
            bm_op.pool_clr     = 1'b1;
            bm_op.pool_clr_idx = free_idx_ff;
            vts_valid_in[free_idx_ff] = 1'b0;
            if (code != '0 && slot_num < mav_pkg::SlotCodeW'(mav_pkg::SLOT_COUNT)) begin
               bm_op.slot_clr     = 1'b1;
               bm_op.slot_clr_idx = mav_pkg::SlotIdxW'(slot_num);
               slot_valid_in      = 1'b1;
               slot_index_in      = 3'(slot_num);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         enable_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
         vts_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         rsp_valid_ff <= rsp_valid_in;
         vts_valid_ff <= vts_valid_in;
      end
      status_ff     <= status_in;
      irq_out_ff    <= irq_out_in;
      msi_data_ff   <= msi_data_in;
      slot_valid_ff <= slot_valid_in;
      slot_index_ff <= slot_index_in;
      rd_valid_ff   <= rd_valid_in;
      free_idx_ff   <= free_idx_in;
   end

   a_wait_gives_item: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT) |=> rsp_valid_ff && (status_ff == mav_pkg::STATUS_OK))
      else $error("free lookup did not produce an item");

   a_no_take_in_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT) |-> !req_chan.ready)
      else $error("item taken during free lookup");

   a_disabled_alloc: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.command == mav_pkg::CMD_ALLOC && !enable_ff)
      |=> (status_ff == mav_pkg::STATUS_DISABLED) && !slot_valid_ff)
      else $error("allocate while disabled was not refused");

   a_slot_needs_vector: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> bm_op.alloc_set && bm_stat.pool_found)
      else $error("slot paired without an allocated vector");

endmodule

// ===== rtl/mav_ram.sv =====
// mav_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module mav_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mav_bitmap.sv =====
// mav_bitmap: pool and slot occupancy bitmaps with lowest-free-entry search.
// Depends on mav_pkg.
module mav_bitmap (
   input  logic                     clock,
   input  logic                     reset,
   input  mav_pkg::bitmap_op_type   op,
   output mav_pkg::bitmap_stat_type stat
);

   logic [mav_pkg::POOL_SIZE-1:0]  pool_ff;
   logic [mav_pkg::POOL_SIZE-1:0]  pool_in;
   logic [mav_pkg::SLOT_COUNT-1:0] slot_ff;
   logic [mav_pkg::SLOT_COUNT-1:0] slot_in;

   always_comb begin
      stat = '0;
      for (int i = mav_pkg::POOL_SIZE - 1; i >= 0; i--) begin
         if (!pool_ff[i]) begin
            stat.pool_found = 1'b1;
            stat.pool_idx   = mav_pkg::PoolIdxW'(i);
         end
      end
      for (int s = mav_pkg::SLOT_COUNT - 1; s >= 0; s--) begin
         if (!slot_ff[s]) begin
            stat.slot_found = 1'b1;
            stat.slot_idx   = mav_pkg::SlotIdxW'(s);
         end
      end
   end

   always_comb begin
      pool_in = pool_ff;
      slot_in = slot_ff;
      if (op.alloc_set && stat.pool_found) begin
         pool_in[stat.pool_idx] = 1'b1;
         if (stat.slot_found) begin
            slot_in[stat.slot_idx] = 1'b1;
         end
      end
      if (op.pool_clr) begin
         pool_in[op.pool_clr_idx] = 1'b0;
      end
      if (op.slot_clr) begin
         slot_in[op.slot_clr_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff <= mav_pkg::PoolResetVal;
         slot_ff <= '0;
      end else begin
         pool_ff <= pool_in;
         slot_ff <= slot_in;
      end
   end

endmodule
